>>> rtl/core/gvfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gvfm_pkg;

  localparam int unsigned MaxDim   = 32;
  localparam int unsigned GridRows = MaxDim * MaxDim;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SIZE_X   = 2'd0,
    REG_SIZE_Y   = 2'd1,
    REG_SIZE_Z   = 2'd2,
    REG_MODEL_ID = 2'd3
  } reg_idx_t;

  // input command codes
  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic       command;
    logic [4:0] vox_x;
    logic [4:0] vox_y;
    logic [4:0] vox_z;
    logic       occupied;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  direction;
    logic [5:0]  plane;
    logic [4:0]  u_start;
    logic [5:0]  u_end;
    logic [4:0]  v_start;
    logic [5:0]  v_end;
    logic [5:0]  rect_width;
    logic [5:0]  rect_height;
    logic [15:0] model_tag;
    logic        done_res;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_word_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_WR_RD, ST_WR_WR, ST_SEEK, ST_LD_INIT,
    ST_LD_A, ST_LD_B, ST_LD_C, ST_LX_A, ST_LX_B,
    ST_SCAN, ST_RUN, ST_MARK, ST_EMIT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_WR_RD, OP_WR_WR, OP_NEXT_DIR, OP_NEXT_LAYER,
    OP_DONE, OP_LD_INIT, OP_LD_SELF, OP_LD_NBR, OP_LD_ROW,
    OP_LX_RD, OP_LX_BIT, OP_SCAN, OP_RUN, OP_MARK, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dir_end;
    logic layer_end;
    logic loaded;
    logic is_x;
    logic ld_last_row;
    logic lx_last;
    logic row_end;
    logic row_hit;
    logic run_stop;
    logic mark_end;
    logic out_busy;
  } dp_status_t;

  // size register as used: zero acts as one, clipped to the grid
  function automatic logic [5:0] eff_size(input logic [5:0] s);
    logic [5:0] r;
    r = s;
    if (s == 6'd0) r = 6'd1;
    else if (s > 6'(MaxDim)) r = 6'(MaxDim);
    return r;
  endfunction

  // ones in the low n bits
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    return ~(32'hFFFF_FFFF << n);
  endfunction

  // index of the lowest set bit, 32 when none
  function automatic logic [5:0] first_one(input logic [31:0] v);
    logic [5:0] r;
    r = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/gvfm_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gvfm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gvfm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gvfm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/core/gvfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gvfm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_command,
  input  wire gvfm_pkg::dp_status_t  stat,
  output logic                       idle,
  output gvfm_pkg::ctrl_cmd_t        cmd
);
  gvfm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= gvfm_pkg::ST_CLR;
    else     state <= state_next;
  end

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = gvfm_pkg::OP_NONE;
    idle       = 1'b0;
    unique case (state)
      gvfm_pkg::ST_CLR: begin
        cmd.op = gvfm_pkg::OP_CLR;
        if (stat.clr_last) state_next = gvfm_pkg::ST_IDLE;
      end
      gvfm_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          if (in_command == gvfm_pkg::CMD_REQUEST) state_next = gvfm_pkg::ST_SEEK;
          else state_next = gvfm_pkg::ST_WR_RD;
        end
      end
      gvfm_pkg::ST_WR_RD: begin
        cmd.op = gvfm_pkg::OP_WR_RD;
        state_next = gvfm_pkg::ST_WR_WR;
      end
      gvfm_pkg::ST_WR_WR: begin
        cmd.op = gvfm_pkg::OP_WR_WR;
        state_next = gvfm_pkg::ST_IDLE;
      end
      gvfm_pkg::ST_SEEK: begin
        if (stat.dir_end) state_next = gvfm_pkg::ST_DONE;
        else if (stat.layer_end) cmd.op = gvfm_pkg::OP_NEXT_DIR;
        else if (!stat.loaded) state_next = gvfm_pkg::ST_LD_INIT;
        else state_next = gvfm_pkg::ST_SCAN;
      end
      gvfm_pkg::ST_LD_INIT: begin
        cmd.op = gvfm_pkg::OP_LD_INIT;
        state_next = stat.is_x ? gvfm_pkg::ST_LX_A : gvfm_pkg::ST_LD_A;
      end
      gvfm_pkg::ST_LD_A: begin
        cmd.op = gvfm_pkg::OP_LD_SELF;
        state_next = gvfm_pkg::ST_LD_B;
      end
      gvfm_pkg::ST_LD_B: begin
        cmd.op = gvfm_pkg::OP_LD_NBR;
        state_next = gvfm_pkg::ST_LD_C;
      end
      gvfm_pkg::ST_LD_C: begin
        cmd.op = gvfm_pkg::OP_LD_ROW;
        state_next = stat.ld_last_row ? gvfm_pkg::ST_SCAN : gvfm_pkg::ST_LD_A;
      end
      gvfm_pkg::ST_LX_A: begin
        cmd.op = gvfm_pkg::OP_LX_RD;
        state_next = gvfm_pkg::ST_LX_B;
      end
      gvfm_pkg::ST_LX_B: begin
        cmd.op = gvfm_pkg::OP_LX_BIT;
        state_next = stat.lx_last ? gvfm_pkg::ST_SCAN : gvfm_pkg::ST_LX_A;
      end
      gvfm_pkg::ST_SCAN: begin
        if (stat.row_end) begin
          cmd.op = gvfm_pkg::OP_NEXT_LAYER;
          state_next = gvfm_pkg::ST_SEEK;
        end else begin
          cmd.op = gvfm_pkg::OP_SCAN;
          if (stat.row_hit) state_next = gvfm_pkg::ST_RUN;
        end
      end
      gvfm_pkg::ST_RUN: begin
        cmd.op = gvfm_pkg::OP_RUN;
        if (stat.run_stop) state_next = gvfm_pkg::ST_MARK;
      end
      gvfm_pkg::ST_MARK: begin
        if (stat.mark_end) state_next = gvfm_pkg::ST_EMIT;
        else cmd.op = gvfm_pkg::OP_MARK;
      end
      gvfm_pkg::ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op = gvfm_pkg::OP_EMIT;
          state_next = gvfm_pkg::ST_IDLE;
        end
      end
      gvfm_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.op = gvfm_pkg::OP_DONE;
          state_next = gvfm_pkg::ST_IDLE;
        end
      end
      default: state_next = gvfm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/gvfm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gvfm_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gvfm_pkg::ctrl_cmd_t  cmd,
  input  wire logic                 in_take,
  input  wire gvfm_pkg::in_word_t   in_word,
  input  wire logic                 cfg_take,
  input  wire gvfm_pkg::cfg_word_t  cfg_word,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output gvfm_pkg::out_word_t       out_word,
  output gvfm_pkg::dp_status_t      stat
);
  localparam int AddrW = $clog2(gvfm_pkg::GridRows);

  // configuration
  logic [5:0]  size_x, size_y, size_z;
  logic [15:0] model_id;

  // latched input word
  gvfm_pkg::in_word_t wr_word;

  // sweep position
  logic [2:0] dir;
  logic [5:0] layer, row, col;
  logic       loaded;

  // layer loading
  logic [4:0]  ld_u, ld_v;
  logic [31:0] self_row;
  logic [AddrW-1:0] clr_cnt;

  // free cells of the layer: exposed and not yet covered
  logic [31:0] free_map [gvfm_pkg::MaxDim];

  // face under construction
  logic [4:0]  u0, v0;
  logic [5:0]  h, wmin, best_w, best_h, a;
  logic [10:0] best_area;

  // grid memory, one row of x per (z,y)
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]      ram_wdata, ram_rdata;

  gvfm_ram #(.Width(gvfm_pkg::MaxDim), .Depth(gvfm_pkg::GridRows)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // extents of the current direction
  logic [5:0] sx, sy, sz, du, dv, dw;
  always_comb begin
    sx = gvfm_pkg::eff_size(size_x);
    sy = gvfm_pkg::eff_size(size_y);
    sz = gvfm_pkg::eff_size(size_z);
    if (dir < 3'd2) begin
      du = sz; dv = sy; dw = sx;
    end else if (dir < 3'd4) begin
      du = sx; dv = sz; dw = sy;
    end else begin
      du = sx; dv = sy; dw = sz;
    end
  end

  // neighbour layer along the normal
  logic [5:0] w_nbr;
  logic       nbr_ok;
  assign w_nbr  = dir[0] ? (layer - 6'd1) : (layer + 6'd1);
  assign nbr_ok = dir[0] ? (layer != 6'd0) : (w_nbr < dw);

  // memory address and write data
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    ram_wdata[wr_word.vox_x] = wr_word.occupied;
    case (cmd.op)
      gvfm_pkg::OP_CLR: begin
        ram_addr  = clr_cnt;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      gvfm_pkg::OP_WR_RD, gvfm_pkg::OP_WR_WR: begin
        ram_addr = {wr_word.vox_z, wr_word.vox_y};
        ram_we   = (cmd.op == gvfm_pkg::OP_WR_WR);
      end
      gvfm_pkg::OP_LD_SELF:
        ram_addr = dir[2] ? {layer[4:0], ld_v} : {ld_v, layer[4:0]};
      gvfm_pkg::OP_LD_NBR:
        ram_addr = dir[2] ? {w_nbr[4:0], ld_v} : {ld_v, w_nbr[4:0]};
      default:
        ram_addr = {ld_u, ld_v};
    endcase
  end

  // free map read port
  logic [5:0]  run_v, mark_v;
  logic [4:0]  fidx;
  logic [31:0] frow;
  assign run_v  = {1'b0, v0} + h;
  assign mark_v = {1'b0, v0} + a;
  always_comb begin
    case (cmd.op)
      gvfm_pkg::OP_RUN:  fidx = run_v[4:0];
      gvfm_pkg::OP_MARK: fidx = mark_v[4:0];
      default:           fidx = row[4:0];
    endcase
  end
  assign frow = free_map[fidx];

  // scan: first free cell at or after the column
  logic [31:0] cand;
  logic [5:0]  hit;
  assign cand = frow & (32'hFFFF_FFFF << col) & gvfm_pkg::low_mask(du);
  assign hit  = gvfm_pkg::first_one(cand);

  // run length of a row from u0
  logic [5:0]  limit, run, wmin_n, h_n;
  logic [31:0] shifted;
  logic [11:0] area;
  assign limit   = du - {1'b0, u0};
  assign shifted = (frow >> u0) & gvfm_pkg::low_mask(limit);
  assign run     = gvfm_pkg::first_one(~shifted) > limit ? limit
                 : gvfm_pkg::first_one(~shifted);
  assign h_n     = h + 6'd1;
  assign wmin_n  = (h == 6'd0 || run < wmin) ? run : wmin;
  assign area    = wmin_n * h_n;

  // exposed bit for the x sweep
  logic [5:0] w_p;
  logic       lx_bit;
  assign w_p    = w_nbr;
  assign lx_bit = ram_rdata[layer[4:0]] & ~(nbr_ok & ram_rdata[w_p[4:0]]);

  logic [5:0] ld_u_n, ld_v_n;
  assign ld_u_n = {1'b0, ld_u} + 6'd1;
  assign ld_v_n = {1'b0, ld_v} + 6'd1;

  // status to the controller
  assign stat.clr_last    = (clr_cnt == AddrW'(gvfm_pkg::GridRows - 1));
  assign stat.dir_end     = dir > 3'd5;
  assign stat.layer_end   = layer >= dw;
  assign stat.loaded      = loaded;
  assign stat.is_x        = dir < 3'd2;
  assign stat.ld_last_row = ld_v_n >= dv;
  assign stat.lx_last     = (ld_u_n >= du) && (ld_v_n >= dv);
  assign stat.row_end     = row >= dv;
  assign stat.row_hit     = cand != 32'd0;
  assign stat.run_stop    = (run_v >= dv) || (run == 6'd0);
  assign stat.mark_end    = a >= best_h;
  assign stat.out_busy    = out_valid & ~out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= 6'(gvfm_pkg::MaxDim);
      size_y   <= 6'(gvfm_pkg::MaxDim);
      size_z   <= 6'(gvfm_pkg::MaxDim);
      model_id <= '0;
    end else if (cfg_take) begin
      unique case (cfg_word.index)
        gvfm_pkg::REG_SIZE_X:   size_x   <= cfg_word.value[5:0];
        gvfm_pkg::REG_SIZE_Y:   size_y   <= cfg_word.value[5:0];
        gvfm_pkg::REG_SIZE_Z:   size_z   <= cfg_word.value[5:0];
        gvfm_pkg::REG_MODEL_ID: model_id <= cfg_word.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) wr_word <= in_word;
  end

  // sweep position and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dir     <= '0;
      layer   <= '0;
      row     <= '0;
      col     <= '0;
      loaded  <= 1'b0;
      clr_cnt <= '0;
    end else begin
      case (cmd.op)
        gvfm_pkg::OP_CLR: clr_cnt <= clr_cnt + AddrW'(1);
        gvfm_pkg::OP_NEXT_DIR: begin
          dir    <= dir + 3'd1;
          layer  <= '0;
          row    <= '0;
          col    <= '0;
          loaded <= 1'b0;
        end
        gvfm_pkg::OP_NEXT_LAYER: begin
          layer  <= layer + 6'd1;
          row    <= '0;
          col    <= '0;
          loaded <= 1'b0;
        end
        gvfm_pkg::OP_DONE: begin
          dir    <= '0;
          layer  <= '0;
          row    <= '0;
          col    <= '0;
          loaded <= 1'b0;
        end
        gvfm_pkg::OP_LD_INIT: loaded <= 1'b1;
        gvfm_pkg::OP_SCAN: begin
          if (cand != 32'd0) begin
            col <= hit + 6'd1;
          end else begin
            row <= row + 6'd1;
            col <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // layer load, face measure and cover
  always_ff @(posedge clk) begin
    case (cmd.op)
      gvfm_pkg::OP_LD_INIT: begin
        for (int i = 0; i < gvfm_pkg::MaxDim; i++) free_map[i] <= '0;
        ld_u <= '0;
        ld_v <= '0;
      end
      gvfm_pkg::OP_LD_NBR: self_row <= ram_rdata;
      gvfm_pkg::OP_LD_ROW: begin
        free_map[ld_v] <= self_row & ~(nbr_ok ? ram_rdata : 32'd0) & gvfm_pkg::low_mask(du);
        ld_v <= ld_v_n[4:0];
      end
      gvfm_pkg::OP_LX_BIT: begin
        free_map[ld_v][ld_u] <= lx_bit;
        if (ld_u_n >= du) begin
          ld_u <= '0;
          ld_v <= ld_v_n[4:0];
        end else begin
          ld_u <= ld_u_n[4:0];
        end
      end
      gvfm_pkg::OP_SCAN: begin
        u0        <= hit[4:0];
        v0        <= row[4:0];
        h         <= '0;
        a         <= '0;
        best_area <= '0;
        best_w    <= '0;
        best_h    <= '0;
      end
      gvfm_pkg::OP_RUN: begin
        if (!((run_v >= dv) || (run == 6'd0))) begin
          h    <= h_n;
          wmin <= wmin_n;
          if (area > {1'b0, best_area}) begin
            best_area <= area[10:0];
            best_w    <= wmin_n;
            best_h    <= h_n;
          end
        end
      end
      gvfm_pkg::OP_MARK: begin
        free_map[mark_v[4:0]] <= frow & ~(gvfm_pkg::low_mask(best_w) << u0);
        a <= a + 6'd1;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gvfm_pkg::OP_EMIT || cmd.op == gvfm_pkg::OP_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gvfm_pkg::OP_EMIT) begin
      out_word.direction   <= dir;
      out_word.plane       <= dir[0] ? layer : layer + 6'd1;
      out_word.u_start     <= u0;
      out_word.u_end       <= {1'b0, u0} + best_w;
      out_word.v_start     <= v0;
      out_word.v_end       <= {1'b0, v0} + best_h;
      out_word.rect_width  <= best_w;
      out_word.rect_height <= best_h;
      out_word.model_tag   <= model_id;
      out_word.done_res    <= 1'b0;
    end else if (cmd.op == gvfm_pkg::OP_DONE) begin
      // done word: every field zero except the marker
      out_word <= '{done_res: 1'b1, default: '0};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/greedy_voxel_face_mesher.sv
`timescale 1ns / 1ps
`default_nettype none
// Greedy face mesher for a 32x32x32 voxel grid.
// cmd  : input words. command 0 writes one voxel (no result);
//        command 1 asks for the next merged face (exactly one result word).
// face : result words, a face rectangle or a done word; done rewinds the
//        sweep to +X, layer 0.
// cfg  : register writes (sizes, model id), always ready; write only when idle.
// A request does bookkeeping plus, when a new layer is entered, a
// mask load: row by row (own row read, neighbour row read, row store)
// for Y/Z sweeps, cell by cell for X sweeps (single grid memory port).
// Then mask rows are scanned, run rows measured and covered rows
// marked, one row at a time.
// The result sits in an output register; a stalled receiver holds the
// block in its emit or done state, while writes and config wait/flow.
// Reset: synchronous, then a clearing pass over all 1024 rows of the grid
// memory during which cmd.ready stays low.
module greedy_voxel_face_mesher (
  input wire logic     clk,
  input wire logic     rst,
  gvfm_chan_if.sink    cmd,
  gvfm_chan_if.source  face,
  gvfm_chan_if.sink    cfg
);
  gvfm_pkg::ctrl_cmd_t  ctl;
  gvfm_pkg::dp_status_t stat;
  gvfm_pkg::in_word_t   in_word;
  gvfm_pkg::cfg_word_t  cfg_word;
  gvfm_pkg::out_word_t  out_word;
  logic idle, out_valid;

  assign in_word    = cmd.data;
  assign cfg_word   = cfg.data;
  assign cmd.ready  = idle;
  assign cfg.ready  = 1'b1;
  assign face.valid = out_valid;
  assign face.data  = out_word;

  gvfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_command (in_word.command),
    .stat       (stat),
    .idle       (idle),
    .cmd        (ctl)
  );

  gvfm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .in_take   (cmd.valid & idle),
    .in_word   (in_word),
    .cfg_take  (cfg.valid),
    .cfg_word  (cfg_word),
    .out_ready (face.ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .stat      (stat)
  );
endmodule
`default_nettype wire

>>> test/tb_greedy_voxel_face_mesher.sv
`timescale 1ns / 1ps
module tb_greedy_voxel_face_mesher;

  localparam int DIR_PX = 0;
  localparam int DIR_PY = 2;
  localparam int DIR_PZ = 4;
  localparam int DIR_LAST = 5;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_DIM = gvfm_pkg::MaxDim;
  localparam int GRID_ROWS = gvfm_pkg::GridRows;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gvfm_chan_if #(.T(gvfm_pkg::in_word_t))  cmd_if ();
  gvfm_chan_if #(.T(gvfm_pkg::out_word_t)) face_if ();
  gvfm_chan_if #(.T(gvfm_pkg::cfg_word_t)) cfg_if ();

  greedy_voxel_face_mesher u_dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_if),
    .face (face_if),
    .cfg  (cfg_if)
  );

  always #1 clk = ~clk;

  // shadow of the mesher state
  bit          grid [MAX_DIM*MAX_DIM*MAX_DIM];
  bit          lmask [GRID_ROWS];
  bit          seen [GRID_ROWS];
  int          runs [MAX_DIM];
  logic [5:0]  sz_x, sz_y, sz_z;
  logic [15:0] model_no;
  int          cur_dir, cur_layer, cur_row, cur_col;
  bit          layer_in;

  gvfm_pkg::out_word_t face_q [$];
  int          errors;
  int          items;
  int          send_pct;
  int          stall_pct;
  bit          last_done;

  function automatic int eff(logic [5:0] s);
    if (s == 6'd0) return 1;
    if (s > 6'(MAX_DIM)) return MAX_DIM;
    return int'(s);
  endfunction

  function automatic bit solid(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0) return 1'b0;
    if (x >= eff(sz_x) || y >= eff(sz_y) || z >= eff(sz_z)) return 1'b0;
    return grid[(z*MAX_DIM + y)*MAX_DIM + x];
  endfunction

  // extents along u, v and the sweep axis
  function automatic void span(input int d, output int du, output int dv, output int dw);
    if (d < DIR_PY) begin
      du = eff(sz_z); dv = eff(sz_y); dw = eff(sz_x);
    end else if (d < DIR_PZ) begin
      du = eff(sz_x); dv = eff(sz_z); dw = eff(sz_y);
    end else begin
      du = eff(sz_x); dv = eff(sz_y); dw = eff(sz_z);
    end
  endfunction

  function automatic bit exposed(int d, int u, int v, int w);
    int x, y, z, nx, ny, nz, st;
    st = (d % 2 == 0) ? 1 : -1;
    if (d < DIR_PY) begin
      x = w; y = v; z = u;
    end else if (d < DIR_PZ) begin
      x = u; z = v; y = w;
    end else begin
      x = u; y = v; z = w;
    end
    nx = x; ny = y; nz = z;
    if (d < DIR_PY) nx += st;
    else if (d < DIR_PZ) ny += st;
    else nz += st;
    return solid(x, y, z) && !solid(nx, ny, nz);
  endfunction

  function automatic bit open_cell(int u, int v);
    return lmask[v*MAX_DIM + u] && !seen[v*MAX_DIM + u];
  endfunction

  // take the largest rectangle anchored at (u,v), first height on ties
  function automatic gvfm_pkg::out_word_t grow_face(int u, int v, int du, int dv);
    gvfm_pkg::out_word_t r;
    int rows, wmin, area, best_a, best_w, best_h, run;
    rows = 0; wmin = 0; best_a = 0; best_w = 0; best_h = 0;
    while (v + rows < dv) begin
      run = 0;
      while (u + run < du && open_cell(u + run, v + rows)) run++;
      if (run == 0) break;
      runs[rows] = run;
      rows++;
    end
    for (int h = 1; h <= rows; h++) begin
      if (h == 1 || runs[h-1] < wmin) wmin = runs[h-1];
      area = wmin * h;
      if (area > best_a) begin
        best_a = area; best_w = wmin; best_h = h;
      end
    end
    for (int a = 0; a < best_h; a++)
      for (int b = 0; b < best_w; b++) seen[(v + a)*MAX_DIM + u + b] = 1'b1;
    r = '0;
    r.direction   = 3'(cur_dir);
    r.plane       = 6'((cur_dir % 2 == 0) ? cur_layer + 1 : cur_layer);
    r.u_start     = 5'(u);
    r.u_end       = 6'(u + best_w);
    r.v_start     = 5'(v);
    r.v_end       = 6'(v + best_h);
    r.rect_width  = 6'(best_w);
    r.rect_height = 6'(best_h);
    r.model_tag   = model_no;
    return r;
  endfunction

  function automatic void rewind();
    cur_dir = DIR_PX; cur_layer = 0; cur_row = 0; cur_col = 0; layer_in = 1'b0;
  endfunction

  function automatic gvfm_pkg::out_word_t next_face();
    gvfm_pkg::out_word_t r;
    int du, dv, dw;
    r = '0;
    forever begin
      if (cur_dir > DIR_LAST) begin
        r.done_res = 1'b1;
        rewind();
        return r;
      end
      span(cur_dir, du, dv, dw);
      if (cur_layer >= dw) begin
        cur_dir++; cur_layer = 0; cur_row = 0; cur_col = 0; layer_in = 1'b0;
        continue;
      end
      // mask is captured on entry to the layer
      if (!layer_in) begin
        for (int i = 0; i < GRID_ROWS; i++) begin
          lmask[i] = 1'b0; seen[i] = 1'b0;
        end
        for (int v = 0; v < dv; v++)
          for (int u = 0; u < du; u++)
            lmask[v*MAX_DIM + u] = exposed(cur_dir, u, v, cur_layer);
        layer_in = 1'b1;
      end
      while (cur_row < dv) begin
        if (cur_col >= du) begin
          cur_row++; cur_col = 0;
          continue;
        end
        if (open_cell(cur_col, cur_row)) begin
          r = grow_face(cur_col, cur_row, du, dv);
          cur_col++;
          return r;
        end
        cur_col++;
      end
      cur_layer++; cur_row = 0; cur_col = 0; layer_in = 1'b0;
    end
  endfunction

  task automatic report(string field, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (t=%0t)", field, got, want, $time);
  endtask

  // send one command word and update the shadow state on acceptance
  task automatic send_cmd(gvfm_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_pct) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    do @(posedge clk); while (!cmd_if.ready);
    items++;
    if (w.command == gvfm_pkg::CMD_REQUEST) begin
      face_q.insert(face_q.size(), next_face());
      last_done = face_q[$].done_res;
    end else begin
      grid[(int'(w.vox_z)*MAX_DIM + int'(w.vox_y))*MAX_DIM + int'(w.vox_x)] = w.occupied;
    end
  endtask

  function automatic gvfm_pkg::in_word_t voxel(int x, int y, int z, bit occ);
    gvfm_pkg::in_word_t w;
    w.command = gvfm_pkg::CMD_WRITE;
    w.vox_x = 5'(x); w.vox_y = 5'(y); w.vox_z = 5'(z);
    w.occupied = occ;
    return w;
  endfunction

  function automatic gvfm_pkg::in_word_t request();
    gvfm_pkg::in_word_t w;
    w = gvfm_pkg::in_word_t'(17'($urandom));
    w.command = gvfm_pkg::CMD_REQUEST;
    return w;
  endfunction

  task automatic sweep_all();
    last_done = 1'b0;
    while (!last_done) send_cmd(request());
  endtask

  // quiet the command channel and let every pending face come back
  task automatic drain();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(gvfm_pkg::reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      gvfm_pkg::REG_SIZE_X:   sz_x = value[5:0];
      gvfm_pkg::REG_SIZE_Y:   sz_y = value[5:0];
      gvfm_pkg::REG_SIZE_Z:   sz_z = value[5:0];
      gvfm_pkg::REG_MODEL_ID: model_no = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_sizes(int x, int y, int z, int id);
    write_reg(gvfm_pkg::REG_SIZE_X, 16'(x));
    write_reg(gvfm_pkg::REG_SIZE_Y, 16'(y));
    write_reg(gvfm_pkg::REG_SIZE_Z, 16'(z));
    write_reg(gvfm_pkg::REG_MODEL_ID, 16'(id));
  endtask

  // odd sizes: zero, oversize, a voxel beyond the extents, rewrite to empty
  task automatic test_edges();
    send_pct = 0; stall_pct = 0;
    set_sizes(0, 1, 63, 16'hFFFF);
    send_cmd(voxel(0, 0, 0, 1'b1));
    send_cmd(voxel(0, 0, 31, 1'b1));
    send_cmd(voxel(31, 31, 31, 1'b1));
    send_cmd(voxel(0, 0, 5, 1'b1));
    send_cmd(voxel(0, 0, 5, 1'b0));
    send_cmd(voxel(0, 0, 7, 1'b1));
    sweep_all();
    sweep_all();
    drain();
  endtask

  // full grid with merge shapes: a slab, an L (tie on area) and a lone cell
  task automatic test_full_grid();
    set_sizes(32, 32, 32, 16'h5A5A);
    send_cmd(voxel(0, 0, 0, 1'b1));
    send_cmd(voxel(1, 0, 0, 1'b1));
    send_cmd(voxel(0, 1, 0, 1'b1));
    send_cmd(voxel(1, 1, 0, 1'b1));
    send_cmd(voxel(10, 10, 10, 1'b1));
    send_cmd(voxel(11, 10, 10, 1'b1));
    send_cmd(voxel(10, 11, 10, 1'b1));
    send_cmd(voxel(31, 31, 31, 1'b1));
    sweep_all();
    drain();
  endtask

  task automatic test_random(int sp, int rp, int n, bit wide);
    int stop, kind, ex, ey, ez;
    send_pct = sp; stall_pct = rp;
    if (wide) set_sizes($urandom_range(32, 63), $urandom_range(0, 2), $urandom_range(1, 2),
                        $urandom);
    else set_sizes($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6), $urandom);
    ex = eff(sz_x); ey = eff(sz_y); ez = eff(sz_z);
    stop = items + n;
    while (items < stop) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 9) == 0)
            send_cmd(voxel($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), $urandom_range(0, 1)));
          else
            send_cmd(voxel($urandom_range(0, ex - 1), $urandom_range(0, ey - 1),
                           $urandom_range(0, ez - 1), $urandom_range(0, 4) != 0));
        end
        repeat ($urandom_range(1, 6)) send_cmd(request());
      end else if (kind < 8) begin
        sweep_all();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1))
            send_cmd(request());
          else
            send_cmd(gvfm_pkg::in_word_t'({gvfm_pkg::CMD_WRITE, 16'($urandom)}));
        end
      end
    end
    sweep_all();
    drain();
  endtask

  // receiver stalls
  always @(negedge clk) face_if.ready <= ($urandom_range(0, 99) >= stall_pct);

  // compare each returned face with the oldest prediction
  always @(posedge clk) begin
    gvfm_pkg::out_word_t got, want;
    if (!rst && face_if.valid && face_if.ready) begin
      got = face_if.data;
      if (face_q.size() == 0) begin
        report("unexpected word", int'(got), 0);
      end else begin
        want = face_q.pop_front();
        if (got.direction != want.direction)
          report("direction", got.direction, want.direction);
        if (got.plane != want.plane) report("plane", got.plane, want.plane);
        if (got.u_start != want.u_start) report("u_start", got.u_start, want.u_start);
        if (got.u_end != want.u_end) report("u_end", got.u_end, want.u_end);
        if (got.v_start != want.v_start) report("v_start", got.v_start, want.v_start);
        if (got.v_end != want.v_end) report("v_end", got.v_end, want.v_end);
        if (got.rect_width != want.rect_width)
          report("rect_width", got.rect_width, want.rect_width);
        if (got.rect_height != want.rect_height)
          report("rect_height", got.rect_height, want.rect_height);
        if (got.model_tag != want.model_tag)
          report("model_tag", got.model_tag, want.model_tag);
        if (got.done_res != want.done_res) report("done_res", got.done_res, want.done_res);
      end
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    face_if.ready = 1'b0;
    errors = 0; items = 0; send_pct = 0; stall_pct = 0;
    sz_x = 6'd32; sz_y = 6'd32; sz_z = 6'd32; model_no = '0;
    rewind();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edges();
    test_full_grid();
    test_random(0, 0, 230, 1'b0);
    test_random(54, 0, 230, 1'b0);
    test_random(0, 54, 230, 1'b0);
    test_random(26, 26, 230, 1'b1);
    if (errors == 0 && face_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
